[src/apm_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Audio peak/RMS meter package
// Shared widths, codes and the command group that the controller sends to
// the datapath.
// ============================================================================
package apm_pkg;

   // Width of the saturating sample counter.
   localparam int COUNT_BITS = 24;

   // Field widths.
   localparam int KIND_W     = 2;
   localparam int RAW_W      = 32;
   localparam int SILENT_W   = 20;
   localparam int LEVEL_W    = 24;
   localparam int RMS_W      = 17;
   localparam int TOTAL_W    = 24;
   localparam int FMT_W      = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   // Accumulator and report arithmetic widths.
   localparam int SUM_W      = 56;
   localparam int SQ_W       = 33;
   // The Q2.46 square drops its low 14 bits to become Q1.32.
   localparam int SQ_SHIFT   = 14;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int CNT_SUM_W  = ((COUNT_BITS > SILENT_W) ? COUNT_BITS : SILENT_W) + 1;
   localparam int TOT_CMP_W  = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SILENT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

   // Sample formats.
   localparam logic [FMT_W-1:0] FMT_INT16   = 3'd0;
   localparam logic [FMT_W-1:0] FMT_INT24   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_INT32   = 3'd2;
   localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_FORMAT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_THRESHOLD = 1'd1;

   // Reset values and limits.
   localparam logic [FMT_W-1:0]      FMT_RESET  = FMT_FLOAT32;
   localparam logic [LEVEL_W-1:0]    CLIP_RESET = 24'd8220836;
   localparam logic [LEVEL_W-1:0]    FULL_SCALE = 24'h800000;
   localparam logic [RMS_W-1:0]      RMS_CAP    = 17'd65536;
   localparam logic [TOTAL_W-1:0]    TOTAL_MAX  = {TOTAL_W{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [SUM_W-1:0]      SUM_MAX    = {SUM_W{1'b1}};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sample_go;
      logic silent_go;
      logic report_load;
      logic div_step;
      logic sqrt_step;
      logic out_load;
   } apm_cmd_type;

endpackage

[src/apm_req_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// Meter request channel
// Valid/ready channel carrying one input item per beat.
// ============================================================================
interface apm_req_if
   import apm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [RAW_W-1:0]    raw_sample;
   logic [SILENT_W-1:0] silent_count;

   modport source (output valid, kind, raw_sample, silent_count, input ready);
   modport sink   (input valid, kind, raw_sample, silent_count, output ready);
endinterface

[src/apm_rsp_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// Meter response channel
// Valid/ready channel carrying one level report per beat.
// ============================================================================
interface apm_rsp_if
   import apm_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] peak_level;
   logic [RMS_W-1:0]   rms_level;
   logic [TOTAL_W-1:0] sample_total;
   logic               clipping;

   modport source (output valid, peak_level, rms_level, sample_total, clipping,
                   input ready);
   modport sink   (input valid, peak_level, rms_level, sample_total, clipping,
                   output ready);
endinterface

[src/apm_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// Meter datapath
// Sample conversion, peak and square-sum accumulation, counter, the
// bit-serial divider and square root, and the response register.
// ============================================================================
module apm_datapath
   import apm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  apm_cmd_type           cmd,
   input  logic [RAW_W-1:0]      raw_sample,
   input  logic [SILENT_W-1:0]   silent_count,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [LEVEL_W-1:0]    peak_level,
   output logic [RMS_W-1:0]      rms_level,
   output logic [TOTAL_W-1:0]    sample_total,
   output logic                  clipping
);

   // Configuration registers.
   logic [FMT_W-1:0]      fmt_ff, fmt_in;
   logic [LEVEL_W-1:0]    clip_thr_ff, clip_thr_in;

   // Accumulation state.
   logic [LEVEL_W-1:0]    mag_ff, mag_in;
   logic                  sq_vld_ff, sq_vld_in;
   logic [LEVEL_W-1:0]    peak_ff, peak_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   // Report engine.
   logic [COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic [SUM_W-1:0]      work_ff, work_in;
   logic [COUNT_BITS-1:0] drem_ff, drem_in;
   logic [SREM_W-1:0]     srem_ff, srem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [LEVEL_W-1:0]    peak_hold_ff, peak_hold_in;
   logic [TOTAL_W-1:0]    total_hold_ff, total_hold_in;
   logic                  clip_hold_ff, clip_hold_in;
   logic                  empty_hold_ff, empty_hold_in;

   // Response register.
   logic [LEVEL_W-1:0]    rsp_peak_ff, rsp_peak_in;
   logic [RMS_W-1:0]      rsp_rms_ff, rsp_rms_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                  rsp_clip_ff, rsp_clip_in;

   // Combinational helpers.
   logic [LEVEL_W-1:0]     mag;
   logic [16:0]            neg16;
   logic [24:0]            neg24;
   logic [32:0]            neg32;
   logic [32:0]            rnd32;
   logic [7:0]             fexp;
   logic [22:0]            fman;
   logic [7:0]             fsh;
   logic [LEVEL_W-1:0]     fsig;
   logic [2*LEVEL_W-1:0]   prod;
   logic [SQ_W-1:0]        sq;
   logic [SUM_W:0]         sum_wide;
   logic [CNT_SUM_W-1:0]   cnt_add;
   logic [TOT_CMP_W-1:0]   cnt_ext;
   logic [COUNT_BITS:0]    dshift;
   logic [COUNT_BITS:0]    ddiff;
   logic                   dge;
   logic [SREM_W+1:0]      sshift;
   logic [SREM_W+1:0]      strial;
   logic [SREM_W+1:0]      sdiff;
   logic                   sge;
   logic [RMS_W-1:0]       rms_final;

   // Convert the raw sample to the magnitude of its Q1.23 level.
   always_comb begin
      neg16 = 17'h10000 - {1'b0, raw_sample[15:0]};
      neg24 = 25'h1000000 - {1'b0, raw_sample[23:0]};
      neg32 = 33'h1_0000_0000 - {1'b0, raw_sample};
      rnd32 = neg32 + 33'd255;
      fexp  = raw_sample[30:23];
      fman  = raw_sample[22:0];
      fsh   = 8'd127 - fexp;
      fsig  = {1'b1, fman};
      case (fmt_ff)
         FMT_INT16: begin
            mag = raw_sample[15] ? {neg16[15:0], 8'h00} : {raw_sample[15:0], 8'h00};
         end
         FMT_INT24: begin
            mag = raw_sample[23] ? neg24[23:0] : raw_sample[23:0];
         end
         FMT_INT32: begin
            mag = raw_sample[31] ? rnd32[31:8] : raw_sample[31:8];
         end
         FMT_FLOAT32: begin
            // NaN reads as silence; one and above saturates; tiny values vanish.
            if (fexp == 8'hFF && fman != 23'd0) begin
               mag = '0;
            end else if (fexp >= 8'd127) begin
               mag = FULL_SCALE;
            end else if (fexp == 8'd0 || fsh >= 8'd24) begin
               mag = '0;
            end else begin
               mag = fsig >> fsh[4:0];
            end
         end
         default: begin
            mag = '0;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      fmt_in      = fmt_ff;
      clip_thr_in = clip_thr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SAMPLE_FORMAT:  fmt_in      = csr_wdata[FMT_W-1:0];
            CSR_CLIP_THRESHOLD: clip_thr_in = csr_wdata[LEVEL_W-1:0];
         endcase
      end
   end

   // Square of the staged magnitude, Q1.32.
   always_comb begin
      prod     = mag_ff * mag_ff;
      sq       = prod[SQ_SHIFT +: SQ_W];
      sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(sq);
   end

   // Counter update, saturating.
   always_comb begin
      if (cmd.sample_go) begin
         cnt_add = CNT_SUM_W'(count_ff) + CNT_SUM_W'(1);
      end else if (cmd.silent_go) begin
         cnt_add = CNT_SUM_W'(count_ff) + CNT_SUM_W'(silent_count);
      end else begin
         cnt_add = CNT_SUM_W'(count_ff);
      end
      cnt_ext = TOT_CMP_W'(count_ff);
   end

   // Accumulation: stage one latches the magnitude, stage two folds it in.
   always_comb begin
      mag_in    = cmd.sample_go ? mag : mag_ff;
      sq_vld_in = cmd.sample_go;
      peak_in   = peak_ff;
      sum_in    = sum_ff;
      if (sq_vld_ff) begin
         if (mag_ff > peak_ff) begin
            peak_in = mag_ff;
         end
         sum_in = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      end
      count_in = (cnt_add > CNT_SUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                    : cnt_add[COUNT_BITS-1:0];
      if (cmd.report_load) begin
         peak_in  = '0;
         sum_in   = '0;
         count_in = '0;
      end
   end

   // One restoring divide step and one square root step.
   always_comb begin
      dshift = {drem_ff, work_ff[SUM_W-1]};
      ddiff  = dshift - {1'b0, divisor_ff};
      dge    = !ddiff[COUNT_BITS];
      sshift = {srem_ff, work_ff[SUM_W-1 -: 2]};
      strial = {2'b00, root_ff, 2'b01};
      sdiff  = sshift - strial;
      sge    = (sshift >= strial);
   end

   // Report engine: snapshot, divide, then square root on the quotient.
   always_comb begin
      divisor_in    = divisor_ff;
      work_in       = work_ff;
      drem_in       = drem_ff;
      srem_in       = srem_ff;
      root_in       = root_ff;
      peak_hold_in  = peak_hold_ff;
      total_hold_in = total_hold_ff;
      clip_hold_in  = clip_hold_ff;
      empty_hold_in = empty_hold_ff;
      if (cmd.report_load) begin
         divisor_in    = count_ff;
         work_in       = sum_ff;
         drem_in       = '0;
         srem_in       = '0;
         root_in       = '0;
         peak_hold_in  = peak_ff;
         total_hold_in = (cnt_ext > TOT_CMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                           : cnt_ext[TOTAL_W-1:0];
         clip_hold_in  = (peak_ff >= clip_thr_ff);
         empty_hold_in = (count_ff == '0);
      end else if (cmd.div_step) begin
         drem_in = dge ? ddiff[COUNT_BITS-1:0] : dshift[COUNT_BITS-1:0];
         work_in = {work_ff[SUM_W-2:0], dge};
      end else if (cmd.sqrt_step) begin
         srem_in = sge ? sdiff[SREM_W-1:0] : sshift[SREM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], sge};
         work_in = {work_ff[SUM_W-3:0], 2'b00};
      end
   end

   // Response register, loaded when the report is finished.
   always_comb begin
      if (empty_hold_ff) begin
         rms_final = '0;
      end else if (root_ff > ROOT_W'(RMS_CAP)) begin
         rms_final = RMS_CAP;
      end else begin
         rms_final = root_ff[RMS_W-1:0];
      end
      rsp_peak_in  = cmd.out_load ? peak_hold_ff  : rsp_peak_ff;
      rsp_rms_in   = cmd.out_load ? rms_final     : rsp_rms_ff;
      rsp_total_in = cmd.out_load ? total_hold_ff : rsp_total_ff;
      rsp_clip_in  = cmd.out_load ? clip_hold_ff  : rsp_clip_ff;
   end

   // State with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= FMT_RESET;
         clip_thr_ff <= CLIP_RESET;
         sq_vld_ff   <= 1'b0;
         peak_ff     <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         fmt_ff      <= fmt_in;
         clip_thr_ff <= clip_thr_in;
         sq_vld_ff   <= sq_vld_in;
         peak_ff     <= peak_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mag_ff        <= mag_in;
      divisor_ff    <= divisor_in;
      work_ff       <= work_in;
      drem_ff       <= drem_in;
      srem_ff       <= srem_in;
      root_ff       <= root_in;
      peak_hold_ff  <= peak_hold_in;
      total_hold_ff <= total_hold_in;
      clip_hold_ff  <= clip_hold_in;
      empty_hold_ff <= empty_hold_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_rms_ff    <= rsp_rms_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   assign peak_level   = rsp_peak_ff;
   assign rms_level    = rsp_rms_ff;
   assign sample_total = rsp_total_ff;
   assign clipping     = rsp_clip_ff;

endmodule

[src/apm_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// Meter controller
// Accepts request beats, sequences the divide and square root of a report
// and owns the response valid flag.
// ============================================================================
module apm_ctrl
   import apm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output apm_cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOAD = 5'b00010,
      S_DIV  = 5'b00100,
      S_SQRT = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state, step counter and datapath commands.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_SAMPLE: cmd.sample_go = 1'b1;
                  KIND_SILENT: cmd.silent_go = 1'b1;
                  KIND_REPORT: state_in      = S_LOAD;
                  default: ;
               endcase
            end
         end
         S_LOAD: begin
            cmd.report_load = 1'b1;
            step_in         = '0;
            state_in        = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_SQRT;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_DONE: begin
            // Wait for the response register to free up.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid flag.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/audio_peak_rms_meter.sv]
`timescale 1ns / 1ps
// ============================================================================
// Audio peak and RMS level meter
// Top level: request and response channels, configuration port, controller
// and datapath.
// ============================================================================
// Usage:
//   req_bus carries one item per beat: a sample (kind 0), a silent run
//   (kind 1) or a report request (kind 2). rsp_bus returns one beat per
//   report with peak, RMS, sample count and clipping flag.
//   Samples and silent runs are taken one per cycle while no report runs;
//   a sample's square is folded into the sum in the cycle after its beat.
//   A report holds off req_bus while it takes a snapshot, runs the
//   bit-serial divider (sum / count) and then the square root, and loads
//   the response register. Its beat appears on rsp_bus the cycle after
//   that load.
//   When rsp_bus stalls, samples keep being accepted; a following report
//   runs its divide and square root but then waits until the previous
//   response beat is taken.
//   The csr port writes sample_format (index 0) and clip_threshold
//   (index 1); write only while the meter is idle.
//   Synchronous reset clears the accumulators and the response valid and
//   restores float32 format and the default clip threshold.
// ============================================================================
module audio_peak_rms_meter
   import apm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   apm_req_if.sink               req_bus,
   apm_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   apm_cmd_type cmd;

   // Sequencing and handshakes.
   apm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // Arithmetic and result register.
   apm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .raw_sample   (req_bus.raw_sample),
      .silent_count (req_bus.silent_count),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .peak_level   (rsp_bus.peak_level),
      .rms_level    (rsp_bus.rms_level),
      .sample_total (rsp_bus.sample_total),
      .clipping     (rsp_bus.clipping)
   );

endmodule
